// ===== sv/csw_pkg.sv =====
// Shared types and constants for the curvature smoothing weight core.
// No dependencies; used by every module of the block.
package csw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int KH_W       = DATA_WIDTH - 1;
  localparam int DELTA_W    = 2 * KH_W - FRAC_BITS + 1;
  localparam int RAD_W      = 2 * DATA_WIDTH;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int K_W        = DATA_WIDTH + 2;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int NUM_W      = KH_W + FRAC_BITS;
  localparam int W_W        = 18;

  localparam logic signed [W_W-1:0] W_ONE_FIX   = W_W'(1 << FRAC_BITS);
  localparam logic [Q_W-1:0]        NEG_TENTH_M = Q_W'(((1 << FRAC_BITS) + 5) / 10);

  typedef enum logic [1:0] {
    WT_ONE,
    WT_ZERO,
    WT_RATIO
  } wt_code_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] k1_sat;
    logic [DATA_WIDTH-1:0] k2_sat;
    wt_code_t              code;
    logic                  neg;
  } csw_side_t;

endpackage

// ===== sv/curvature_smoothing_weight_core.sv =====
// Top level of the curvature smoothing weight core.
// Depends on csw_pkg, csw_sqrt and csw_div.
//
// Usage:
//   Input requests: drive in_mean_curv and in_gauss_curv and raise start.
//   busy is low outside reset, so a request is taken on every cycle start is high.
//   Results: out_valid is high for one cycle with out_max_principal,
//   out_min_principal and out_smooth_weight; the receiver must take them.
//   Configuration: cfg_flat_threshold is written when cfg_valid is high;
//   cfg_ready is high outside reset. Write it only while no request is in flight.
// Pipeline: input register, delta, 32 square root stages, weight decision,
//   17 divider stages, output register.
// Throughput: one request per cycle, set by the fully pipelined square
//   root and divider.
// Reset: rst_n (synchronous) empties the pipeline and clears the
//   threshold to zero. No results appear until new requests arrive.
module curvature_smoothing_weight_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [csw_pkg::KH_W-1:0]            in_mean_curv,
  input  logic signed [csw_pkg::DATA_WIDTH-1:0] in_gauss_curv,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csw_pkg::KH_W-1:0]            cfg_flat_threshold,
  output logic                                out_valid,
  output logic signed [csw_pkg::DATA_WIDTH-1:0] out_max_principal,
  output logic signed [csw_pkg::DATA_WIDTH-1:0] out_min_principal,
  output logic signed [csw_pkg::W_W-1:0]      out_smooth_weight
);
  import csw_pkg::*;

  localparam logic signed [K_W-1:0] SAT_MAX = K_W'((64'd1 << (DATA_WIDTH-1)) - 1);
  localparam logic signed [K_W-1:0] SAT_MIN = -SAT_MAX - K_W'(1);

  logic [KH_W-1:0] thr_r;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_flat_threshold;
    end
  end

  // stage 0: capture request
  logic                         s0_vld_r;
  logic [KH_W-1:0]              s0_kh_r;
  logic signed [DATA_WIDTH-1:0] s0_kg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start;
    end
    s0_kh_r <= in_mean_curv;
    s0_kg_r <= in_gauss_curv;
  end

  // stage 1: delta = max(kh*kh >> F - kg, 0)
  logic [2*KH_W-1:0]        sq_full;
  logic signed [DELTA_W:0]  delta_s;
  logic                     s1_vld_r;
  logic [DELTA_W-1:0]       s1_delta_r;
  logic [KH_W-1:0]          s1_kh_r;

  always_comb begin
    sq_full = s0_kh_r * s0_kh_r;
    delta_s = $signed({1'b0, DELTA_W'(sq_full >> FRAC_BITS)})
              - (DELTA_W+1)'(s0_kg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_delta_r <= delta_s[DELTA_W] ? '0 : delta_s[DELTA_W-1:0];
    s1_kh_r    <= s0_kh_r;
  end

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [KH_W-1:0]   sq_kh;

  csw_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld_r),
    .in_rad   (RAD_W'(s1_delta_r) << FRAC_BITS),
    .in_kh    (s1_kh_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_kh   (sq_kh)
  );

  // weight decision on exact principal curvatures
  logic signed [K_W-1:0] k1, k2, kh_s, t_s, a1, a2;
  csw_side_t             side_nxt;
  logic [KH_W-1:0]       num_nxt;

  always_comb begin
    kh_s = K_W'(sq_kh);
    t_s  = K_W'(thr_r);
    k1   = kh_s + K_W'(sq_root);
    k2   = kh_s - K_W'(sq_root);
    a1   = k1[K_W-1] ? -k1 : k1;
    a2   = k2[K_W-1] ? -k2 : k2;
    side_nxt.k1_sat = (k1 > SAT_MAX) ? DATA_WIDTH'(SAT_MAX) : DATA_WIDTH'(k1);
    side_nxt.k2_sat = (k2 < SAT_MIN) ? DATA_WIDTH'(SAT_MIN) : DATA_WIDTH'(k2);
    side_nxt.code   = WT_ONE;
    side_nxt.neg    = 1'b0;
    num_nxt         = '0;
    priority if (a1 <= t_s && a2 <= t_s) begin
      side_nxt.code = WT_ONE;
    end else if (a1 > t_s && a2 > t_s &&
                 ((k1 > 0 && k2 > 0) || (k1 < 0 && k2 < 0))) begin
      side_nxt.code = WT_ZERO;
    end else if (a1 <= a2 && a1 <= kh_s) begin
      side_nxt.code = (sq_kh == '0) ? WT_ONE : WT_RATIO;
      side_nxt.neg  = k1[K_W-1];
      num_nxt       = KH_W'(a1);
    end else if (a2 <= a1 && a2 <= kh_s) begin
      side_nxt.code = (sq_kh == '0) ? WT_ONE : WT_RATIO;
      side_nxt.neg  = k2[K_W-1];
      num_nxt       = KH_W'(a2);
    end else begin
      side_nxt.code = WT_ONE;
    end
  end

  logic            s2_vld_r;
  csw_side_t       s2_side_r;
  logic [KH_W-1:0] s2_num_r, s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= sq_vld;
    end
    s2_side_r <= side_nxt;
    s2_num_r  <= num_nxt;
    s2_den_r  <= (sq_kh == '0) ? KH_W'(1) : sq_kh;
  end

  logic           dv_vld;
  logic [Q_W-1:0] dv_quot;
  csw_side_t      dv_side;

  csw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s2_vld_r),
    .in_num   (s2_num_r),
    .in_den   (s2_den_r),
    .in_side  (s2_side_r),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  // final weight: sign and clamp at -0.1
  logic signed [W_W-1:0] w_nxt;

  always_comb begin
    unique case (dv_side.code)
      WT_ZERO:  w_nxt = '0;
      WT_RATIO: begin
        if (!dv_side.neg) begin
          w_nxt = W_W'(dv_quot);
        end else if (dv_quot > NEG_TENTH_M) begin
          w_nxt = -W_W'(NEG_TENTH_M);
        end else begin
          w_nxt = -W_W'(dv_quot);
        end
      end
      default:  w_nxt = W_ONE_FIX;
    endcase
  end

  logic                         out_vld_r;
  logic signed [DATA_WIDTH-1:0] k1_r, k2_r;
  logic signed [W_W-1:0]        w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
    k1_r <= dv_side.k1_sat;
    k2_r <= dv_side.k2_sat;
    w_r  <= w_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_max_principal = k1_r;
  assign out_min_principal = k2_r;
  assign out_smooth_weight = w_r;

endmodule

// ===== sv/csw_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on csw_pkg; carries the mean curvature alongside.
module csw_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [csw_pkg::RAD_W-1:0] in_rad,
  input  logic [csw_pkg::KH_W-1:0]  in_kh,
  output logic                      out_vld,
  output logic [csw_pkg::ROOT_W-1:0] out_root,
  output logic [csw_pkg::KH_W-1:0]  out_kh
);
  import csw_pkg::*;

  logic              vld_r  [ROOT_W+1];
  logic [RAD_W-1:0]  rad_r  [ROOT_W+1];
  logic [REM_W-1:0]  rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [KH_W-1:0]   kh_r   [ROOT_W+1];

  always_comb begin
    vld_r[0]  = in_vld;
    rad_r[0]  = in_rad;
    rem_r[0]  = '0;
    root_r[0] = '0;
    kh_r[0]   = in_kh;
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W+1:0] rem_nxt;
    logic [REM_W+1:0] trial;
    logic             take;

    always_comb begin
      // bring down the next two radicand bits
      rem_nxt = {rem_r[s], rad_r[s][RAD_W-1 -: 2]};
      trial   = {2'b00, root_r[s], 2'b01};
      take    = (rem_nxt >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rad_r[s+1]  <= {rad_r[s][RAD_W-3:0], 2'b00};
      rem_r[s+1]  <= take ? REM_W'(rem_nxt - trial) : REM_W'(rem_nxt);
      root_r[s+1] <= {root_r[s][ROOT_W-2:0], take};
      kh_r[s+1]   <= kh_r[s];
    end
  end

  assign out_vld  = vld_r[ROOT_W];
  assign out_root = root_r[ROOT_W];
  assign out_kh   = kh_r[ROOT_W];

endmodule

// ===== sv/csw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on csw_pkg; carries the result side band alongside.
module csw_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [csw_pkg::KH_W-1:0] in_num,
  input  logic [csw_pkg::KH_W-1:0] in_den,
  input  csw_pkg::csw_side_t       in_side,
  output logic                     out_vld,
  output logic [csw_pkg::Q_W-1:0]  out_quot,
  output csw_pkg::csw_side_t       out_side
);
  import csw_pkg::*;

  logic             vld_r  [Q_W+1];
  logic [NUM_W-1:0] rem_r  [Q_W+1];
  logic [KH_W-1:0]  den_r  [Q_W+1];
  logic [Q_W-1:0]   quot_r [Q_W+1];
  csw_side_t        side_r [Q_W+1];

  always_comb begin
    vld_r[0]  = in_vld;
    rem_r[0]  = {in_num, {FRAC_BITS{1'b0}}};
    den_r[0]  = in_den;
    quot_r[0] = '0;
    side_r[0] = in_side;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [NUM_W+Q_W-1:0] dsh;
    logic                 take;

    always_comb begin
      dsh  = (NUM_W+Q_W)'(den_r[s]) << B;
      take = ((NUM_W+Q_W)'(rem_r[s]) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rem_r[s+1]  <= take ? NUM_W'((NUM_W+Q_W)'(rem_r[s]) - dsh) : rem_r[s];
      quot_r[s+1] <= quot_r[s] | (Q_W'(take) << B);
      den_r[s+1]  <= den_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_vld  = vld_r[Q_W];
  assign out_quot = quot_r[Q_W];
  assign out_side = side_r[Q_W];

endmodule
